// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while the active-low reset is applied.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Shorthand for the usual clock and reset names.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/cad_pkg.sv =====
// Package of the circular array deque: request kinds, result status codes and
// controller state encoding. No dependencies.
package cad_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2,
        STATUS_RESERVED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    localparam int unsigned WORD_W = 32;

endpackage

// ===== rtl/circular_array_deque.sv =====
// Circular array deque: double-ended queue of DEPTH 32-bit words in one
// synchronous memory. Depends on cad_pkg.
//
//   Channel  | Ports                       | Direction | Carries
//   ---------+-----------------------------+-----------+--------------------------
//   request  | s_valid s_ready s_kind      | in        | push/pop kind and word
//            | s_value                     |           |
//   result   | m_valid m_ready m_status    | out       | outcome, popped word,
//            | m_popped m_now_empty m_now_full|        | empty and full flags
//
// A push or a refused request goes straight to the output register: the result
// is registered at the next edge, and a new request can be taken then if m_ready is high.
// A successful pop passes through the read state, as the slot memory registers
// its read data; the request channel is held off during the read state.
// Synchronous active-low reset empties the deque at once; no clearing pass.
// A result waiting on m_ready is taken in the same cycle as the next request.
module circular_array_deque #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_kind,
    input  logic signed [31:0]          s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic signed [31:0]          m_popped,
    output logic                        m_now_empty,
    output logic                        m_now_full
);
    import cad_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Slot memory: written at one address, read at one address, read data
    // registered. Entries are only ever read after a push wrote them.
    logic [WORD_W-1:0] slots [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              empty_reg, empty_next;
    state_t            state_reg, state_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [WORD_W-1:0] m_popped_reg, m_popped_next;
    logic              m_empty_reg, m_empty_next;
    logic              m_full_reg, m_full_next;

    logic              accept;
    logic              is_full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    kind_t             kind;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    assign kind = kind_t'(s_kind);

    // The deque is full when it holds entries and the slot after the tail is
    // the head.
    assign is_full = !empty_reg && (idx_inc(tail_reg) == head_reg);

    // New requests are taken only in idle, and only when the output register
    // is free or is being emptied at this very edge.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        state_next    = state_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_popped_next = m_popped_reg;
        m_empty_next  = m_empty_reg;
        m_full_next   = m_full_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_status_next = STATUS_DONE;
                    m_popped_next = '0;
                    m_valid_next  = 1'b1;
                    unique case (kind)
                        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                            if (is_full) begin
                                m_status_next = STATUS_OVERFLOW;
                            end else if (empty_reg) begin
                                // First entry always lands in slot zero.
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                            end else if (kind == KIND_PUSH_FRONT) begin
                                head_next = idx_dec(head_reg);
                                wr_en     = 1'b1;
                                wr_addr   = idx_dec(head_reg);
                            end else begin
                                tail_next = idx_inc(tail_reg);
                                wr_en     = 1'b1;
                                wr_addr   = idx_inc(tail_reg);
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_REAR: begin
                            if (empty_reg) begin
                                m_status_next = STATUS_UNDERFLOW;
                            end else begin
                                // The word arrives from memory next cycle.
                                rd_en        = 1'b1;
                                rd_addr      = (kind == KIND_POP_FRONT) ? head_reg : tail_reg;
                                m_valid_next = 1'b0;
                                state_next   = ST_READ;
                                if (head_reg == tail_reg) begin
                                    empty_next = 1'b1;
                                    head_next  = '0;
                                    tail_next  = '0;
                                end else if (kind == KIND_POP_FRONT) begin
                                    head_next = idx_inc(head_reg);
                                end else begin
                                    tail_next = idx_dec(tail_reg);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    m_empty_next = empty_next;
                    m_full_next  = !empty_next && (idx_inc(tail_next) == head_next);
                end
            end
            ST_READ: begin
                m_valid_next  = 1'b1;
                m_popped_next = rd_data_reg;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slots[wr_addr] <= s_value;
        end
        if (rd_en) begin
            rd_data_reg <= slots[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            empty_reg   <= 1'b1;
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            empty_reg   <= empty_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_popped_reg <= m_popped_next;
        m_empty_reg  <= m_empty_next;
        m_full_reg   <= m_full_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_popped    = m_popped_reg;
    assign m_now_empty = m_empty_reg;
    assign m_now_full  = m_full_reg;

endmodule

// ===== rtl/cad_checker.sv =====
// Port-level checker for circular_array_deque, bound to the top level.
// Depends on cad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cad_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [1:0]          s_kind,
    input logic signed [31:0]  s_value,
    input logic                m_valid,
    input logic                m_ready,
    input logic [1:0]          m_status,
    input logic signed [31:0]  m_popped,
    input logic                m_now_empty,
    input logic                m_now_full
);
    import cad_pkg::*;

    logic        req_waiting;
    logic [34:0] request_bits;
    logic        res_stalled;
    logic [36:0] result_bits;
    logic        oflow_res;
    logic        uflow_res;

    assign req_waiting  = s_valid && !s_ready;
    assign request_bits = {s_valid, s_kind, s_value};
    assign res_stalled  = m_valid && !m_ready;
    assign result_bits  = {m_valid, m_status, m_popped, m_now_empty, m_now_full};
    assign oflow_res    = m_valid && (m_status == STATUS_OVERFLOW);
    assign uflow_res    = m_valid && (m_status == STATUS_UNDERFLOW);

    // A waiting request keeps its contents.
    `ASSERT_STD(a_request_held, req_waiting |=> $stable(request_bits), "stalled request changed")

    // A stalled result keeps its contents.
    `ASSERT_STD(a_result_held, res_stalled |=> $stable(result_bits), "stalled result changed")

    // A deque of two or more slots is never empty and full at once.
    `ASSERT_STD(a_empty_and_full, m_valid |-> !(m_now_empty && m_now_full), "empty and full at once")

    // A refused push means the deque was, and still is, full.
    `ASSERT_STD(a_overflow_full, oflow_res |-> m_now_full, "overflow without full deque")

    // A refused pop leaves an empty deque and returns zero.
    `ASSERT_STD(a_underflow, uflow_res |-> m_now_empty && !(|m_popped), "bad underflow result")

endmodule

bind circular_array_deque cad_checker u_cad_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_kind      (s_kind),
    .s_value     (s_value),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_popped    (m_popped),
    .m_now_empty (m_now_empty),
    .m_now_full  (m_now_full)
);

// ===== verif/tb_circular_array_deque.sv =====
// Self-checking testbench of the circular array deque: it drives push and pop requests,
// predicts every result and compares the result fields.
// Depends on cad_pkg and circular_array_deque.
module tb_circular_array_deque;
    timeunit 1ns;
    timeprecision 1ps;

    import cad_pkg::*;

    localparam int unsigned DEPTH = 8;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned RANDOM_REQUESTS = 1600;
    localparam int unsigned DRAIN_CYCLES = 20;

    // One request as the sender presents it.
    typedef struct {
        kind_t       kind;
        logic [31:0] value;
    } deque_request_t;

    // One result as the block should report it.
    typedef struct {
        status_t            status;
        logic signed [31:0] popped;
        logic               now_empty;
        logic               now_full;
    } deque_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = KIND_PUSH_FRONT;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [31:0] m_popped;
    logic               m_now_empty;
    logic               m_now_full;

    circular_array_deque #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_popped    (m_popped),
        .m_now_empty (m_now_empty),
        .m_now_full  (m_now_full)
    );

    // Ten nanosecond clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Requests waiting to be presented, and results the deque is expected to return.
    deque_request_t pending_requests[$];
    deque_result_t  expected_results[$];

    int unsigned total_requests = 0;
    int unsigned accepted_requests = 0;
    int unsigned error_count = 0;

    // ------------------------------------------------------------------
    // Shadow deque. It is updated at the edge at which a request is
    // accepted, so its contents always match what the block should hold
    // once that request has taken effect.
    // ------------------------------------------------------------------
    logic [31:0]      shadow_slots [DEPTH];
    logic [IDX_W-1:0] shadow_head = '0;
    logic [IDX_W-1:0] shadow_tail = '0;
    logic             shadow_empty = 1'b1;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
    endfunction

    // The deque is full when it holds something and the slot after the rear is the front.
    function automatic logic shadow_is_full();
        return !shadow_empty && (wrap_next(shadow_tail) == shadow_head);
    endfunction

    // Apply one accepted request to the shadow deque and queue the result it must give.
    task automatic apply_request(input kind_t kind, input logic [31:0] value);
        deque_result_t res;
        logic          last_entry;
        res.status = STATUS_DONE;
        res.popped = '0;
        if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR) begin
            if (shadow_is_full()) begin
                // A push into a full deque is refused and changes nothing.
                res.status = STATUS_OVERFLOW;
            end else if (shadow_empty) begin
                // The first entry always lands in slot zero, whichever end it is pushed at.
                shadow_head = '0;
                shadow_tail = '0;
                shadow_empty = 1'b0;
                shadow_slots[0] = value;
            end else if (kind == KIND_PUSH_FRONT) begin
                shadow_head = wrap_prev(shadow_head);
                shadow_slots[shadow_head] = value;
            end else begin
                shadow_tail = wrap_next(shadow_tail);
                shadow_slots[shadow_tail] = value;
            end
        end else begin
            if (shadow_empty) begin
                // A pop from an empty deque is refused and returns zero.
                res.status = STATUS_UNDERFLOW;
            end else begin
                last_entry = (shadow_head == shadow_tail);
                if (kind == KIND_POP_FRONT) begin
                    res.popped = shadow_slots[shadow_head];
                    if (!last_entry) shadow_head = wrap_next(shadow_head);
                end else begin
                    res.popped = shadow_slots[shadow_tail];
                    if (!last_entry) shadow_tail = wrap_prev(shadow_tail);
                end
                // Removing the last entry empties the deque and sends both indices home.
                if (last_entry) begin
                    shadow_empty = 1'b1;
                    shadow_head = '0;
                    shadow_tail = '0;
                end
            end
        end
        res.now_empty = shadow_empty;
        res.now_full = shadow_is_full();
        expected_results.push_back(res);
    endtask

    task automatic add_request(input kind_t kind, input logic [31:0] value);
        deque_request_t req;
        req.kind = kind;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: mismatch on %s, expected %h, actual %h", $time, field, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver. It presents requests in bursts of random length with random
    // gaps between them; a gap of zero joins two bursts, so long stretches
    // with no idling occur too. Valid is assigned once per edge, so a
    // request that follows an accepted one keeps valid high throughout.
    // ------------------------------------------------------------------
    int unsigned    burst_left = 1;
    int unsigned    gap_left = 0;
    deque_request_t next_request;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(kind_t'(s_kind), s_value);
                accepted_requests++;
            end
            // A new request may only be presented once the previous one has gone.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    next_request = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= next_request.kind;
                    s_value <= next_request.value;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. A new receiver mode is drawn when mode_cycles wraps: always
    // ready, ready at random, mostly stalled, or ready when the count is a
    // multiple of four. Each result taken is compared with the oldest expectation.
    // ------------------------------------------------------------------
    int unsigned   stall_mode = 0;
    int unsigned   mode_cycles = 0;
    logic          ready_next;
    deque_result_t oldest_result;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with no request outstanding, status %h popped %h",
                             $time, m_status, m_popped);
                    error_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_status !== oldest_result.status)
                        report_mismatch("status", 32'(oldest_result.status), 32'(m_status));
                    if (m_popped !== oldest_result.popped)
                        report_mismatch("popped", oldest_result.popped, m_popped);
                    if (m_now_empty !== oldest_result.now_empty)
                        report_mismatch("now_empty", 32'(oldest_result.now_empty),
                                        32'(m_now_empty));
                    if (m_now_full !== oldest_result.now_full)
                        report_mismatch("now_full", 32'(oldest_result.now_full),
                                        32'(m_now_full));
                end
            end
            mode_cycles++;
            if (mode_cycles == 64) begin
                mode_cycles = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                2: ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = (mode_cycles % 4 == 0);
            endcase
            m_ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    int unsigned phase_left;
    int unsigned push_percent;
    kind_t       rnd_kind;
    logic [31:0] rnd_value;

    initial begin
        // Directed part. Pops on an empty deque, two pushes at the front of
        // an empty deque (the second wraps the head below zero), a fill to
        // eight entries with the extreme words, pushes refused at both ends
        // of a full deque, a drain from mostly alternating ends to empty, one
        // more pop refused, and single-entry round trips through both ends.
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_REAR, 32'hFFFF_FFFF);
        add_request(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        add_request(KIND_PUSH_FRONT, 32'h8000_0000);
        add_request(KIND_PUSH_REAR, 32'hFFFF_FFFF);
        add_request(KIND_PUSH_REAR, 32'h0000_0000);
        add_request(KIND_PUSH_FRONT, 32'h0000_0001);
        add_request(KIND_PUSH_REAR, 32'hAAAA_AAAA);
        add_request(KIND_PUSH_FRONT, 32'h5555_5555);
        add_request(KIND_PUSH_REAR, 32'h1234_5678);
        add_request(KIND_PUSH_FRONT, 32'hDEAD_BEEF);
        add_request(KIND_PUSH_REAR, 32'hCAFE_F00D);
        add_request(KIND_POP_REAR, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_REAR, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_REAR, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_POP_REAR, 32'h0000_0000);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_PUSH_REAR, 32'h0F0F_0F0F);
        add_request(KIND_POP_FRONT, 32'h0000_0000);
        add_request(KIND_PUSH_FRONT, 32'hF0F0_F0F0);
        add_request(KIND_POP_REAR, 32'h0000_0000);

        // Random part, in phases with a random bias between pushes and pops,
        // so that the deque swings between empty and full and wraps round often.
        phase_left = 0;
        push_percent = 50;
        repeat (RANDOM_REQUESTS) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(4, 40);
                case ($urandom_range(0, 4))
                    0: push_percent = 5;
                    1: push_percent = 30;
                    2: push_percent = 50;
                    3: push_percent = 70;
                    default: push_percent = 95;
                endcase
            end
            phase_left--;
            if ($urandom_range(0, 99) < push_percent)
                rnd_kind = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
            else
                rnd_kind = $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
            case ($urandom_range(0, 15))
                0: rnd_value = 32'h8000_0000;
                1: rnd_value = 32'h7FFF_FFFF;
                2: rnd_value = 32'hFFFF_FFFF;
                3: rnd_value = 32'h0000_0000;
                default: rnd_value = $urandom();
            endcase
            add_request(rnd_kind, rnd_value);
        end
        total_requests = pending_requests.size();

        // Synchronous reset held from the start of the run, released at an edge.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every request has been accepted and every result has come.
        while (accepted_requests < total_requests || expected_results.size() > 0)
            @(posedge aclk);
        // A short tail to catch any stray result.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
